// File: hw/rtl/vie_pkg.sv
// Package: shared constants, register indexes, modes and control structs.
package vie_pkg;

  localparam int MAX_STATES  = 1024;
  localparam int MAX_ACTIONS = 16;
  localparam int MAX_SLOTS   = 8;

  localparam int ST_W     = $clog2(MAX_STATES);
  localparam int AC_W     = $clog2(MAX_ACTIONS);
  localparam int SL_W     = $clog2(MAX_SLOTS);
  localparam int CIDX_W   = ST_W + AC_W;
  localparam int TIDX_W   = CIDX_W + SL_W;
  localparam int VIDX_W   = ST_W + 1;
  localparam int COST_DEPTH = MAX_STATES * MAX_ACTIONS;
  localparam int TW_DEPTH   = COST_DEPTH * MAX_SLOTS;
  localparam int VAL_DEPTH  = 2 * MAX_STATES;
  localparam int Q_W      = 32 + SL_W + 1;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIONS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAP       = 3'd5;

  localparam logic [1:0] MODE_LOAD_COST = 2'd0;
  localparam logic [1:0] MODE_LOAD_TW   = 2'd1;
  localparam logic [1:0] MODE_RUN       = 2'd2;
  localparam logic [1:0] MODE_READ      = 2'd3;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic [16:0] disc;
    logic [30:0] tol;
    logic [10:0] n;
    logic [4:0]  na;
    logic [3:0]  ns;
    logic [15:0] cap;
  } cfg_t;

  typedef struct packed {
    logic              clr_val;
    logic              clr_pol;
    logic [VIDX_W-1:0] clr_addr;
    logic              bank;
    logic [ST_W-1:0]   s;
    logic [AC_W-1:0]   a;
    logic [SL_W-1:0]   k;
    logic              ld_cost;
    logic              ld_tw;
    logic              rd_tgt;
    logic              rd_state;
    logic              q_load;
    logic              mul1;
    logic              mul2;
    logic              mag;
    logic              acc;
    logic              act_end;
    logic              first_act;
    logic              wb;
    logic              maxd_clr;
  } cmd_t;

  typedef struct packed {
    logic within_tol;
  } dp_status_t;

endpackage

// File: hw/rtl/vie_in_if.sv
// Input channel: valid/ready handshake with the command item fields.
interface vie_in_if;
  import vie_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [ST_W-1:0]    state_id;
  logic [AC_W-1:0]    action_index;
  logic [SL_W-1:0]    slot;
  logic [ST_W-1:0]    target_state;
  logic [16:0]        weight;
  logic signed [31:0] step_cost;

  modport source (output valid, mode, state_id, action_index, slot, target_state,
                  weight, step_cost, input ready);
  modport sink (input valid, mode, state_id, action_index, slot, target_state,
                weight, step_cost, output ready);
endinterface

// File: hw/rtl/vie_out_if.sv
// Output channel: valid/ready handshake with the read result fields.
interface vie_out_if;
  import vie_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] cost_to_go;
  logic [AC_W-1:0]    best_action;
  logic [15:0]        iterations;
  logic               converged;

  modport source (output valid, cost_to_go, best_action, iterations, converged,
                  input ready);
  modport sink (input valid, cost_to_go, best_action, iterations, converged,
                output ready);
endinterface

// File: hw/rtl/vie_ram.sv
// Generic single write port, single read port RAM with registered read.
module vie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/vie_datapath.sv
// Datapath: tables, value banks, slot term arithmetic, action minimum, max change.
module vie_datapath (
  input  logic                       clk,
  input  vie_pkg::cmd_t              cmd,
  input  vie_pkg::cfg_t              cfg,
  input  logic [vie_pkg::ST_W-1:0]   in_state,
  input  logic [vie_pkg::AC_W-1:0]   in_action,
  input  logic [vie_pkg::SL_W-1:0]   in_slot,
  input  logic [vie_pkg::ST_W-1:0]   in_target,
  input  logic [16:0]                in_weight,
  input  logic signed [31:0]         in_cost,
  output vie_pkg::dp_status_t        status,
  output logic signed [31:0]         rd_value,
  output logic [vie_pkg::AC_W-1:0]   rd_policy
);
  import vie_pkg::*;

  logic [31:0]        cost_rdata;
  logic [ST_W-1:0]    tgt_rdata;
  logic [16:0]        wgt_rdata;
  logic [31:0]        val_rdata;
  logic [16:0]        wgt_sat;
  logic [VIDX_W-1:0]  val_waddr;
  logic [VIDX_W-1:0]  val_raddr;
  logic [31:0]        val_wdata;
  logic               val_we;
  logic [ST_W-1:0]    pol_waddr;
  logic [AC_W-1:0]    pol_wdata;
  logic               pol_we;

  logic               neg;
  logic [31:0]        aj;
  logic [32:0]        p;
  logic [48:0]        ph;
  logic [47:0]        pl;
  logic [31:0]        mag;
  logic signed [Q_W-1:0] q_acc;
  logic signed [31:0] best;
  logic [AC_W-1:0]    besta;
  logic [32:0]        maxd;

  logic signed [31:0] j_val;
  logic [33:0]        p_full;
  logic [65:0]        mag_sum;
  logic signed [31:0] q_sat;
  logic signed [32:0] diff;
  logic [32:0]        adiff;

  assign wgt_sat = (in_weight > ONE_Q16) ? ONE_Q16 : in_weight;

  vie_ram #(.WIDTH(32), .DEPTH(COST_DEPTH)) u_cost (
    .clk, .we(cmd.ld_cost), .waddr({in_state, in_action}), .wdata(in_cost),
    .raddr({cmd.s, cmd.a}), .rdata(cost_rdata)
  );

  vie_ram #(.WIDTH(ST_W), .DEPTH(TW_DEPTH)) u_tgt (
    .clk, .we(cmd.ld_tw), .waddr({in_state, in_action, in_slot}), .wdata(in_target),
    .raddr({cmd.s, cmd.a, cmd.k}), .rdata(tgt_rdata)
  );

  vie_ram #(.WIDTH(17), .DEPTH(TW_DEPTH)) u_wgt (
    .clk, .we(cmd.ld_tw), .waddr({in_state, in_action, in_slot}), .wdata(wgt_sat),
    .raddr({cmd.s, cmd.a, cmd.k}), .rdata(wgt_rdata)
  );

  // Two value banks: current sweep reads bank, writes the other.
  always_comb begin
    val_we    = cmd.clr_val | cmd.wb;
    val_waddr = cmd.clr_val ? cmd.clr_addr : {~cmd.bank, cmd.s};
    val_wdata = cmd.clr_val ? 32'd0 : best;
    if (cmd.rd_tgt) begin
      val_raddr = {cmd.bank, tgt_rdata};
    end else if (cmd.rd_state) begin
      val_raddr = {cmd.bank, cmd.s};
    end else begin
      val_raddr = {cmd.bank, in_state};
    end
    pol_we    = cmd.clr_pol | cmd.wb;
    pol_waddr = cmd.clr_pol ? cmd.clr_addr[ST_W-1:0] : cmd.s;
    pol_wdata = cmd.clr_pol ? '0 : besta;
  end

  vie_ram #(.WIDTH(32), .DEPTH(VAL_DEPTH)) u_val (
    .clk, .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  vie_ram #(.WIDTH(AC_W), .DEPTH(MAX_STATES)) u_pol (
    .clk, .we(pol_we), .waddr(pol_waddr), .wdata(pol_wdata),
    .raddr(in_state), .rdata(rd_policy)
  );

  assign rd_value = val_rdata;

  always_comb begin
    j_val   = val_rdata;
    p_full  = cfg.disc * wgt_rdata;
    mag_sum = {1'b0, ph, 16'd0} + {18'd0, pl} + 66'h0_8000_0000;
    if (q_acc > Q_W'(32'sh7FFF_FFFF)) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (q_acc < -(Q_W'(33'sh0_8000_0000))) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = q_acc[31:0];
    end
    diff  = 33'(signed'(val_rdata)) - 33'(best);
    adiff = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      neg <= j_val[31];
      aj  <= j_val[31] ? 32'(-j_val) : 32'(j_val);
      p   <= p_full[32:0];
    end
    if (cmd.mul2) begin
      ph <= p[32:16] * aj;
      pl <= p[15:0] * aj;
    end
    if (cmd.mag) begin
      mag <= mag_sum[63:32];
    end
    if (cmd.q_load) begin
      q_acc <= Q_W'(signed'(cost_rdata));
    end else if (cmd.acc) begin
      q_acc <= neg ? q_acc - Q_W'(mag) : q_acc + Q_W'(mag);
    end
    if (cmd.act_end && (cmd.first_act || q_sat < best)) begin
      best  <= q_sat;
      besta <= cmd.a;
    end
    if (cmd.maxd_clr) begin
      maxd <= '0;
    end else if (cmd.wb && adiff > maxd) begin
      maxd <= adiff;
    end
  end

  assign status.within_tol = maxd <= {2'b00, cfg.tol};
endmodule

// File: hw/rtl/vie_controller.sv
// Controller: sequences loads, reads, clearing passes and the sweep loops.
module vie_controller (
  input  logic                clk,
  input  logic                rst,
  input  vie_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  logic                out_free,
  input  vie_pkg::dp_status_t status,
  output logic                in_ready,
  output logic                out_load,
  output logic [15:0]         iterations,
  output logic                converged,
  output vie_pkg::cmd_t       cmd
);
  import vie_pkg::*;

  typedef enum logic [3:0] {
    S_INIT_CLR, S_IDLE, S_RUN_CLR, S_ACT_RD, S_ACT_COST, S_SLOT_RD, S_SLOT_TW,
    S_SLOT_J, S_SLOT_MUL, S_SLOT_MAG, S_SLOT_ACC, S_ACT_END, S_STATE_RD,
    S_STATE_WB, S_SWEEP_END, S_READ_WAIT
  } state_t;

  state_t            state;
  logic [VIDX_W-1:0] clr_cnt;
  logic [ST_W-1:0]   s;
  logic [AC_W-1:0]   a;
  logic [SL_W-1:0]   k;
  logic              bank;
  logic [15:0]       sweeps;
  logic              accept;
  logic [16:0]       sweeps_next;

  assign in_ready    = (state == S_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign out_load    = (state == S_READ_WAIT);
  assign sweeps_next = {1'b0, sweeps} + 17'd1;

  always_comb begin
    cmd           = '0;
    cmd.clr_val   = (state == S_INIT_CLR) || (state == S_RUN_CLR);
    cmd.clr_pol   = (state == S_INIT_CLR);
    cmd.clr_addr  = clr_cnt;
    cmd.bank      = bank;
    cmd.s         = s;
    cmd.a         = a;
    cmd.k         = k;
    cmd.ld_cost   = accept && (in_mode == MODE_LOAD_COST);
    cmd.ld_tw     = accept && (in_mode == MODE_LOAD_TW);
    cmd.rd_tgt    = (state == S_SLOT_TW);
    cmd.rd_state  = (state == S_STATE_RD);
    cmd.q_load    = (state == S_ACT_COST);
    cmd.mul1      = (state == S_SLOT_J);
    cmd.mul2      = (state == S_SLOT_MUL);
    cmd.mag       = (state == S_SLOT_MAG);
    cmd.acc       = (state == S_SLOT_ACC);
    cmd.act_end   = (state == S_ACT_END);
    cmd.first_act = (a == '0);
    cmd.wb        = (state == S_STATE_WB);
    cmd.maxd_clr  = (state == S_RUN_CLR) || (state == S_SWEEP_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT_CLR;
      clr_cnt    <= '0;
      s          <= '0;
      a          <= '0;
      k          <= '0;
      bank       <= 1'b0;
      sweeps     <= '0;
      iterations <= '0;
      converged  <= 1'b0;
    end else begin
      case (state)
        S_INIT_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VIDX_W'(VAL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && in_mode == MODE_RUN) begin
            clr_cnt <= '0;
            state   <= S_RUN_CLR;
          end else if (accept && in_mode == MODE_READ) begin
            state <= S_READ_WAIT;
          end
        end
        S_READ_WAIT: state <= S_IDLE;
        S_RUN_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VIDX_W'(VAL_DEPTH - 1)) begin
            s      <= '0;
            a      <= '0;
            bank   <= 1'b0;
            sweeps <= '0;
            state  <= S_ACT_RD;
          end
        end
        S_ACT_RD: begin
          k     <= '0;
          state <= S_ACT_COST;
        end
        S_ACT_COST: state <= S_SLOT_RD;
        S_SLOT_RD:  state <= S_SLOT_TW;
        S_SLOT_TW:  state <= S_SLOT_J;
        S_SLOT_J:   state <= S_SLOT_MUL;
        S_SLOT_MUL: state <= S_SLOT_MAG;
        S_SLOT_MAG: state <= S_SLOT_ACC;
        S_SLOT_ACC: begin
          if ({1'b0, k} == cfg.ns - 4'd1) begin
            state <= S_ACT_END;
          end else begin
            k     <= k + 1'b1;
            state <= S_SLOT_RD;
          end
        end
        S_ACT_END: begin
          if ({1'b0, a} == cfg.na - 5'd1) begin
            state <= S_STATE_RD;
          end else begin
            a     <= a + 1'b1;
            state <= S_ACT_RD;
          end
        end
        S_STATE_RD: state <= S_STATE_WB;
        S_STATE_WB: begin
          a <= '0;
          if ({1'b0, s} == cfg.n - 11'd1) begin
            state <= S_SWEEP_END;
          end else begin
            s     <= s + 1'b1;
            state <= S_ACT_RD;
          end
        end
        S_SWEEP_END: begin
          bank   <= ~bank;
          sweeps <= sweeps_next[15:0];
          s      <= '0;
          a      <= '0;
          if (status.within_tol) begin
            converged  <= 1'b1;
            iterations <= sweeps_next[15:0];
            state      <= S_IDLE;
          end else if (sweeps_next >= {1'b0, cfg.cap}) begin
            converged  <= 1'b0;
            iterations <= sweeps_next[15:0];
            state      <= S_IDLE;
          end else begin
            state <= S_ACT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/value_iteration_engine.sv
// Top level: configuration registers, controller, datapath and result register.
// Load items are written at acceptance; a read item's result is loaded into the output register in S_READ_WAIT.
// A run first clears both value banks, then sweeps every used state; the slot terms of each
// action pass one at a time through the single shared slot multiplier path.
// Reset is synchronous; afterwards a clearing pass clears the value and policy
// memories, during which no item is accepted.
module value_iteration_engine (
  input  logic                          clk,
  input  logic                          rst,
  vie_in_if.sink                        in_ch,
  vie_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [vie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vie_pkg::CFG_W-1:0]     cfg_data
);
  import vie_pkg::*;

  logic [16:0] discount;
  logic [30:0] tolerance;
  logic [10:0] num_states_used;
  logic [4:0]  num_actions_used;
  logic [3:0]  num_slots_used;
  logic [15:0] iteration_cap;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;
  logic              out_load;
  logic [15:0]       iterations;
  logic              converged;
  logic signed [31:0] rd_value;
  logic [AC_W-1:0]   rd_policy;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      discount         <= ONE_Q16;
      tolerance        <= 31'd1;
      num_states_used  <= 11'd1024;
      num_actions_used <= 5'd16;
      num_slots_used   <= 4'd8;
      iteration_cap    <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISCOUNT:  discount         <= cfg_data[16:0];
        REG_TOLERANCE: tolerance        <= cfg_data[30:0];
        REG_STATES:    num_states_used  <= cfg_data[10:0];
        REG_ACTIONS:   num_actions_used <= cfg_data[4:0];
        REG_SLOTS:     num_slots_used   <= cfg_data[3:0];
        REG_CAP:       iteration_cap    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.disc = (discount > ONE_Q16) ? ONE_Q16 : discount;
    cfg.tol  = tolerance;
    cfg.n    = (num_states_used == '0) ? 11'd1 :
               (num_states_used > 11'(MAX_STATES)) ? 11'(MAX_STATES) : num_states_used;
    cfg.na   = (num_actions_used == '0) ? 5'd1 :
               (num_actions_used > 5'(MAX_ACTIONS)) ? 5'(MAX_ACTIONS) : num_actions_used;
    cfg.ns   = (num_slots_used == '0) ? 4'd1 :
               (num_slots_used > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : num_slots_used;
    cfg.cap  = (iteration_cap == '0) ? 16'd1 : iteration_cap;
  end

  vie_controller u_ctl (
    .clk, .rst, .cfg,
    .in_valid(in_ch.valid), .in_mode(in_ch.mode),
    .out_free(!out_valid || out_ch.ready),
    .status, .in_ready(in_ch.ready), .out_load, .iterations, .converged, .cmd
  );

  vie_datapath u_dp (
    .clk, .cmd, .cfg,
    .in_state(in_ch.state_id), .in_action(in_ch.action_index),
    .in_slot(in_ch.slot), .in_target(in_ch.target_state),
    .in_weight(in_ch.weight), .in_cost(in_ch.step_cost),
    .status, .rd_value, .rd_policy
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.cost_to_go  <= rd_value;
      out_ch.best_action <= rd_policy;
      out_ch.iterations  <= iterations;
      out_ch.converged   <= converged;
    end
  end

  assign out_ch.valid = out_valid;

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.mode == MODE_READ |-> ##2 out_ch.valid)
    else $error("read item gave no result");

  a_conv_iter: assert property (@(posedge clk) disable iff (rst)
    converged |-> iterations != 16'd0)
    else $error("converged with zero sweeps");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_cost || cmd.ld_tw) |-> !cmd.clr_val && !cmd.wb)
    else $error("table load during a run");
endmodule

// File: sim/tb.sv
// Testbench for value_iteration_engine: self-checking, with its own value iteration predictor.
`timescale 1ns / 1ps

module tb;
  import vie_pkg::*;

  localparam longint CYCLE_LIMIT = 10_000_000;

  typedef struct {
    logic [1:0]         mode;
    logic [ST_W-1:0]    st;
    logic [AC_W-1:0]    ac;
    logic [SL_W-1:0]    sl;
    logic [ST_W-1:0]    tg;
    logic [16:0]        wt;
    logic signed [31:0] cost;
  } vi_cmd_t;

  typedef struct {
    logic signed [31:0] cost_to_go;
    logic [AC_W-1:0]    best_action;
    logic [15:0]        iterations;
    logic               converged;
  } state_report_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  vie_in_if  in_bus ();
  vie_out_if out_bus ();

  value_iteration_engine dut (
    .clk(clk), .rst(rst), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [31:0] step_cost_mem [COST_DEPTH];
  bit                 step_cost_set [COST_DEPTH];
  logic [ST_W-1:0]    target_mem    [TW_DEPTH];
  logic [16:0]        weight_mem    [TW_DEPTH];
  bit                 slot_set      [TW_DEPTH];
  int                 value_now     [MAX_STATES];
  int                 value_new     [MAX_STATES];
  logic [AC_W-1:0]    policy_mem    [MAX_STATES];
  logic [15:0]        sweeps_done;
  logic               run_converged;

  logic [16:0] m_disc;
  logic [30:0] m_tol;
  logic [10:0] m_states;
  logic [4:0]  m_actions;
  logic [3:0]  m_slots;
  logic [15:0] m_cap;

  vi_cmd_t       pending_cmds [$];
  state_report_t expected_reports [$];

  int  mismatches = 0;
  int  reports_checked = 0;
  int  loads_taken = 0;
  int  runs_taken = 0;
  int  phases_done = 0;
  bit  no_gaps = 0;
  bit  in_taken = 0;
  longint cycle_count = 0;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic sweep_until_done();
    int unsigned n, na, ns, cap, cnt, e, base;
    longint unsigned disc, maxd, p, aj, mag, ad;
    longint q, d;
    int best, jv;
    logic [AC_W-1:0] besta;
    bit done;
    n    = clamp_to(m_states, MAX_STATES);
    na   = clamp_to(m_actions, MAX_ACTIONS);
    ns   = clamp_to(m_slots, MAX_SLOTS);
    cap  = clamp_to(m_cap, 65535);
    disc = (m_disc > ONE_Q16) ? 65536 : m_disc;
    cnt  = 0;
    done = 0;
    foreach (value_now[i]) value_now[i] = 0;
    while (!done) begin
      maxd = 0;
      for (int s = 0; s < n; s++) begin
        best  = 0;
        besta = '0;
        for (int a = 0; a < na; a++) begin
          base = s * MAX_ACTIONS + a;
          q = step_cost_mem[base];
          for (int k = 0; k < ns; k++) begin
            e  = base * MAX_SLOTS + k;
            jv = value_now[target_mem[e]];
            p  = disc * weight_mem[e];
            aj = (jv < 0) ? longint'(-longint'(jv)) : longint'(jv);
            mag = (p * aj + 64'h8000_0000) >> 32;
            q = (jv < 0) ? q - longint'(mag) : q + longint'(mag);
          end
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          if (a == 0 || int'(q) < best) begin
            best  = int'(q);
            besta = a[AC_W-1:0];
          end
        end
        value_new[s]  = best;
        policy_mem[s] = besta;
      end
      for (int s = 0; s < n; s++) begin
        d  = longint'(value_now[s]) - longint'(value_new[s]);
        ad = (d < 0) ? -d : d;
        if (ad > maxd) maxd = ad;
        value_now[s] = value_new[s];
      end
      cnt++;
      if (maxd <= m_tol) begin
        run_converged = 1;
        done = 1;
      end else if (cnt >= cap) begin
        run_converged = 0;
        done = 1;
      end
    end
    sweeps_done = cnt[15:0];
  endtask

  task automatic apply_command(input vi_cmd_t c);
    state_report_t r;
    int unsigned ci, ti;
    ci = {c.st, c.ac};
    ti = {c.st, c.ac, c.sl};
    case (c.mode)
      MODE_LOAD_COST: begin
        step_cost_mem[ci] = c.cost;
        step_cost_set[ci] = 1;
        loads_taken++;
      end
      MODE_LOAD_TW: begin
        target_mem[ti] = c.tg;
        weight_mem[ti] = (c.wt > ONE_Q16) ? ONE_Q16 : c.wt;
        slot_set[ti]   = 1;
        loads_taken++;
      end
      MODE_RUN: begin
        sweep_until_done();
        runs_taken++;
      end
      default: begin
        r.cost_to_go  = value_now[c.st];
        r.best_action = policy_mem[c.st];
        r.iterations  = sweeps_done;
        r.converged   = run_converged;
        expected_reports.push_back(r);
      end
    endcase
  endtask

  // clock and initial input values
  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 0;
    in_bus.mode = MODE_READ;
    in_bus.state_id = '0;
    in_bus.action_index = '0;
    in_bus.slot = '0;
    in_bus.target_state = '0;
    in_bus.weight = '0;
    in_bus.step_cost = '0;
    out_bus.ready = 0;
    forever #10 clk = ~clk;
  end

  // command driver
  int gap_left = 0;
  always @(negedge clk) begin
    vi_cmd_t c;
    if (rst) begin
      in_bus.valid <= 0;
    end else if (!in_bus.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_bus.mode <= c.mode;
        in_bus.state_id <= c.st;
        in_bus.action_index <= c.ac;
        in_bus.slot <= c.sl;
        in_bus.target_state <= c.tg;
        in_bus.weight <= c.wt;
        in_bus.step_cost <= c.cost;
        in_bus.valid <= 1;
        gap_left = pick_gap();
      end else begin
        in_bus.valid <= 0;
      end
    end
  end

  // result receiver, with one long hold-off
  int  hold_left = 0;
  bit  hold_used = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_bus.ready <= 0;
    end else if (!hold_used && reports_checked >= 20) begin
      hold_used = 1;
      hold_left = 600;
      out_bus.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 0;
    end else begin
      out_bus.ready <= (pick_gap() == 0);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    vi_cmd_t c;
    state_report_t e;
    bit in_fire, out_fire;
    in_fire  = !rst && in_bus.valid && in_bus.ready;
    out_fire = !rst && out_bus.valid && out_bus.ready;
    in_taken <= in_fire;
    if (!rst) cycle_count++;
    if (in_fire) begin
      c.mode = in_bus.mode;
      c.st   = in_bus.state_id;
      c.ac   = in_bus.action_index;
      c.sl   = in_bus.slot;
      c.tg   = in_bus.target_state;
      c.wt   = in_bus.weight;
      c.cost = in_bus.step_cost;
      apply_command(c);
    end
    if (out_fire) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        e = expected_reports.pop_front();
        reports_checked++;
        if (out_bus.cost_to_go !== e.cost_to_go || out_bus.best_action !== e.best_action ||
            out_bus.iterations !== e.iterations || out_bus.converged !== e.converged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp J=%0d a=%0d it=%0d cv=%0b, got J=%0d a=%0d it=%0d cv=%0b",
                     $realtime, e.cost_to_go, e.best_action, e.iterations, e.converged,
                     out_bus.cost_to_go, out_bus.best_action, out_bus.iterations,
                     out_bus.converged);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("value_iteration_engine test failed");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_cost(input int s, input int a, input logic signed [31:0] v);
    vi_cmd_t c;
    c = '{MODE_LOAD_COST, s[ST_W-1:0], a[AC_W-1:0], SL_W'($urandom), ST_W'($urandom),
          17'($urandom), v};
    pending_cmds.push_back(c);
  endtask

  task automatic push_slot(input int s, input int a, input int k, input int t, input int w);
    vi_cmd_t c;
    c = '{MODE_LOAD_TW, s[ST_W-1:0], a[AC_W-1:0], k[SL_W-1:0], t[ST_W-1:0], w[16:0], $urandom};
    pending_cmds.push_back(c);
  endtask

  task automatic push_simple(input logic [1:0] m, input int s);
    vi_cmd_t c;
    c = '{m, s[ST_W-1:0], AC_W'($urandom), SL_W'($urandom), ST_W'($urandom), 17'($urandom),
          $urandom};
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [31:0] mild_cost();
    return $signed($urandom_range(0, 2 ** 21)) - (2 ** 20);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    case (idx)
      REG_DISCOUNT:  m_disc = v[16:0];
      REG_TOLERANCE: m_tol = v[30:0];
      REG_STATES:    m_states = v[10:0];
      REG_ACTIONS:   m_actions = v[4:0];
      REG_SLOTS:     m_slots = v[3:0];
      REG_CAP:       m_cap = v[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int unsigned disc, tol, n, na, ns, cap);
    wait_idle();
    write_reg(REG_DISCOUNT, disc);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_STATES, n);
    write_reg(REG_ACTIONS, na);
    write_reg(REG_SLOTS, ns);
    write_reg(REG_CAP, cap);
  endtask

  task automatic run_phase(input int unsigned disc, tol, n, na, ns, cap,
                           input bit refill_all, input int wmax, input int nrand,
                           input int nreads);
    int un, ua, us, s, a, k;
    configure(disc, tol, n, na, ns, cap);
    no_gaps = ($urandom_range(0, 3) == 0);
    un = clamp_to(m_states, MAX_STATES);
    ua = clamp_to(m_actions, MAX_ACTIONS);
    us = clamp_to(m_slots, MAX_SLOTS);
    // every entry a run will touch must hold a written value
    for (s = 0; s < un; s++)
      for (a = 0; a < ua; a++) begin
        if (refill_all || !step_cost_set[s * MAX_ACTIONS + a]) push_cost(s, a, mild_cost());
        for (k = 0; k < us; k++)
          if (refill_all || !slot_set[(s * MAX_ACTIONS + a) * MAX_SLOTS + k])
            push_slot(s, a, k, $urandom_range(0, un - 1), $urandom_range(0, wmax));
      end
    for (int i = 0; i < nrand; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        s = $urandom_range(0, un - 1);
        a = $urandom_range(0, ua - 1);
        k = $urandom_range(0, us - 1);
        if ($urandom_range(0, 1))
          push_cost(s, a, ($urandom_range(0, 9) < 7) ? mild_cost() : $urandom);
        else
          push_slot(s, a, k, ($urandom_range(0, 99) < 85) ? $urandom_range(0, un - 1)
                                                         : $urandom_range(0, 1023),
                    $urandom_range(0, wmax));
      end else if ($urandom_range(0, 1)) begin
        push_cost($urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
      end else begin
        push_slot($urandom_range(0, 1023), $urandom_range(0, 15), $urandom_range(0, 7),
                  $urandom_range(0, 1023), $urandom_range(0, 131071));
      end
      if ($urandom_range(0, 15) == 0) push_simple(MODE_READ, $urandom_range(0, 1023));
    end
    push_simple(MODE_RUN, 0);
    for (int i = 0; i < nreads; i++)
      push_simple(MODE_READ, ($urandom_range(0, 9) < 8) ? $urandom_range(0, un - 1)
                                                       : $urandom_range(0, 1023));
    phases_done++;
  endtask

  initial begin
    m_disc = ONE_Q16;
    m_tol = 1;
    m_states = 11'd1024;
    m_actions = 5'd16;
    m_slots = 4'd8;
    m_cap = 16'hFFFF;
    sweeps_done = '0;
    run_converged = 0;
    foreach (value_now[i]) begin
      value_now[i] = 0;
      policy_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: saturated costs, weight above one, tie, target beyond the used states
    configure(65536, 1, 2, 2, 2, 3);
    push_simple(MODE_READ, 0);
    push_simple(MODE_READ, 1023);
    push_cost(0, 0, 32'sh7FFF_FFFF);
    push_cost(0, 1, 32'sh7FFF_FFFF);
    push_cost(1, 0, 32'sh8000_0000);
    push_cost(1, 1, -5);
    push_slot(0, 0, 0, 1, 131071);
    push_slot(0, 0, 1, 1023, 65536);
    push_slot(0, 1, 0, 0, 0);
    push_slot(0, 1, 1, 1, 65536);
    push_slot(1, 0, 0, 0, 65536);
    push_slot(1, 0, 1, 1, 65536);
    push_slot(1, 1, 0, 0, 1);
    push_slot(1, 1, 1, 1, 32768);
    push_simple(MODE_RUN, 0);
    push_simple(MODE_READ, 0);
    push_simple(MODE_READ, 1);
    push_simple(MODE_READ, 1023);

    // register extremes, out of range values included
    run_phase(131071, 0, 0, 1, 1, 0, 0, 131071, 10, 4);
    run_phase(0, 32'h7FFF_FFFF, 3, 1, 1, 2, 0, 131071, 10, 6);
    run_phase(1, 100, 1, 31, 15, 2, 0, 131071, 20, 6);
    run_phase(65536, 32'h7FFF_FFFF, 2, 1, 1, 65535, 1, 65536, 4, 3);
    run_phase(32768, 1, 8, 3, 2, 2000, 1, 32768, 0, 8);

    for (int p = 0; p < 8; p++)
      run_phase($urandom_range(0, 131071),
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                            : $urandom_range(0, 4096),
                $urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 3),
                $urandom_range(1, 6), 0, 131071, 20, 10);

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d phases: %0d loads, %0d runs, %0d read results checked",
             phases_done, loads_taken, runs_taken, reports_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("value_iteration_engine test passed");
    end else begin
      $display("value_iteration_engine test failed");
    end
    $finish;
  end

endmodule

// File: value_iteration_engine.f
hw/rtl/vie_pkg.sv
hw/rtl/vie_in_if.sv
hw/rtl/vie_out_if.sv
hw/rtl/vie_ram.sv
hw/rtl/vie_datapath.sv
hw/rtl/vie_controller.sv
hw/rtl/value_iteration_engine.sv
sim/tb.sv
